/* src/assert_macros.svh */
// Assertion macros shared by the hash table engine RTL.
// Sampled on clk, disabled while rst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/chte_pkg.sv */
// Shared types and constants of the chained hash table engine.
// No dependencies; used by every module of the block but chte_bucket_mem.
package chte_pkg;

  localparam int KEY_W     = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 7;
  localparam int HASH_MULT = 13;
  localparam int HASH_W    = 20;
  localparam int ITER_W    = $clog2(HASH_W);

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_RETRIEVE = 2'd1;
  localparam logic [1:0] OP_ALTER    = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic key;
    logic value;
    logic link;
  } node_we_t;

endpackage

/* src/chte_rem_unit.sv */
// Bit-serial restoring remainder unit: (key * 13) mod bucket count.
// Depends on chte_pkg; one dividend bit per cycle.
module chte_rem_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [chte_pkg::HASH_W-1:0]   dividend,
  input  logic [chte_pkg::CFG_W-1:0]    divisor,
  output logic                          done,
  output logic [chte_pkg::CFG_W-1:0]    rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [chte_pkg::ITER_W-1:0]   cnt_r;
  logic [chte_pkg::HASH_W-1:0]   dvd_r;
  logic [chte_pkg::CFG_W-1:0]    div_r;
  logic [chte_pkg::CFG_W-1:0]    rem_r;
  logic [chte_pkg::CFG_W-1:0]    rem_nxt;
  logic [chte_pkg::CFG_W:0]      trial;

  always_comb begin
    trial = {rem_r, dvd_r[chte_pkg::HASH_W-1]};
    if (trial >= {1'b0, div_r}) begin
      trial = trial - {1'b0, div_r};
    end
    rem_nxt = trial[chte_pkg::CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == chte_pkg::ITER_W'(chte_pkg::HASH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* src/chte_bucket_mem.sv */
// Bucket head memory: valid flag and first node of each chain.
// Depends on chte_pkg only through its users; registered read port.
module chte_bucket_mem #(
  parameter  int MAX_BUCKETS = 64,
  parameter  int POOL_NODES  = 256,
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
  localparam int PW = $clog2(POOL_NODES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [BW-1:0] waddr,
  input  logic          wvld,
  input  logic [PW-1:0] wptr,
  input  logic [BW-1:0] raddr,
  output logic          rvld,
  output logic [PW-1:0] rptr
);

  logic [PW:0] mem [MAX_BUCKETS];
  logic [PW:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvld, wptr};
    end
    rdata_r <= mem[raddr];
  end

  assign rvld = rdata_r[PW];
  assign rptr = rdata_r[PW-1:0];

endmodule

/* src/chte_node_mem.sv */
// Node pool memories: key, value and link of every chain node.
// Depends on chte_pkg; one write and one registered read per cycle.
module chte_node_mem #(
  parameter  int POOL_NODES = 256,
  parameter  int VALUE_BITS = 32,
  localparam int PW = $clog2(POOL_NODES)
) (
  input  logic                         clk,
  input  chte_pkg::node_we_t           we,
  input  logic [PW-1:0]                waddr,
  input  logic [chte_pkg::KEY_W-1:0]   wkey,
  input  logic [VALUE_BITS-1:0]        wval,
  input  logic                         wlvld,
  input  logic [PW-1:0]                wlptr,
  input  logic [PW-1:0]                raddr,
  output logic [chte_pkg::KEY_W-1:0]   rkey,
  output logic [VALUE_BITS-1:0]        rval,
  output logic                         rlvld,
  output logic [PW-1:0]                rlptr
);

  logic [chte_pkg::KEY_W-1:0] key_mem  [POOL_NODES];
  logic [VALUE_BITS-1:0]      val_mem  [POOL_NODES];
  logic [PW:0]                link_mem [POOL_NODES];
  logic [chte_pkg::KEY_W-1:0] rkey_r;
  logic [VALUE_BITS-1:0]      rval_r;
  logic [PW:0]                rlink_r;

  always_ff @(posedge clk) begin
    if (we.key) begin
      key_mem[waddr] <= wkey;
    end
    if (we.value) begin
      val_mem[waddr] <= wval;
    end
    if (we.link) begin
      link_mem[waddr] <= {wlvld, wlptr};
    end
    rkey_r  <= key_mem[raddr];
    rval_r  <= val_mem[raddr];
    rlink_r <= link_mem[raddr];
  end

  assign rkey  = rkey_r;
  assign rval  = rval_r;
  assign rlvld = rlink_r[PW];
  assign rlptr = rlink_r[PW-1:0];

endmodule

/* src/chained_hash_table_engine_core.sv */
// Top level of the chained hash table engine: sequencer, register, result beat.
// Depends on chte_pkg, chte_rem_unit, chte_bucket_mem, chte_node_mem.
//
//   port group | direction | beat moves on
//   in_*       | request   | in_valid high, in_stall low
//   out_*      | result    | out_valid high, out_stall low
//   APB        | register  | psel, penable, pwrite, pready high
//
// A request is hashed by the bit-serial remainder unit, reads its bucket
// head and walks the chain; an insert of a new key into a free slot writes
// a node and, in a non-empty bucket, the tail link; an alter the value.
// An unused opcode skips the hash and walk. After reset a clearing pass
// empties every bucket head before the first request beat. A stalled result
// stays in the output register while the next request is hashed and walked.
`include "assert_macros.svh"

module chained_hash_table_engine_core #(
  parameter int MAX_BUCKETS = 64,
  parameter int POOL_NODES  = 256,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [chte_pkg::KEY_W-1:0]    in_key,
  input  logic [chte_pkg::DATA_W-1:0]   in_data_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [chte_pkg::DATA_W-1:0]   out_read_value,
  output logic                          out_collided,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int PW = $clog2(POOL_NODES);
  localparam int UW = $clog2(POOL_NODES + 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b0_0000_0001,
    S_IDLE  = 9'b0_0000_0010,
    S_HASH  = 9'b0_0000_0100,
    S_HEAD  = 9'b0_0000_1000,
    S_NODE  = 9'b0_0001_0000,
    S_WNEW  = 9'b0_0010_0000,
    S_WTAIL = 9'b0_0100_0000,
    S_WALT  = 9'b0_1000_0000,
    S_DONE  = 9'b1_0000_0000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [BW-1:0]                  clr_r, clr_nxt;
  logic [PW-1:0]                  cur_r, cur_nxt;
  logic [UW-1:0]                  used_r, used_nxt;
  logic                           chain_r, chain_nxt;
  logic [1:0]                     op_r, op_nxt;
  logic [chte_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [VALUE_BITS-1:0]          val_r, val_nxt;
  chte_pkg::status_t              res_status_r, res_status_nxt;
  logic [chte_pkg::DATA_W-1:0]    res_val_r, res_val_nxt;
  logic                           res_col_r, res_col_nxt;
  logic [chte_pkg::CFG_W-1:0]     bcount_r;
  logic                           out_valid_r;
  logic [1:0]                     out_status_r;
  logic [chte_pkg::DATA_W-1:0]    out_val_r;
  logic                           out_col_r;
  logic                           out_load;

  logic [chte_pkg::CFG_W-1:0]     divisor;
  logic [chte_pkg::HASH_W-1:0]    hash_in;
  logic                           mod_start;
  logic                           mod_done;
  logic [chte_pkg::CFG_W-1:0]     mod_rem;

  logic                           bkt_we;
  logic [BW-1:0]                  bkt_waddr;
  logic                           bkt_wvld;
  logic [PW-1:0]                  bkt_wptr;
  logic                           hd_vld;
  logic [PW-1:0]                  hd_ptr;

  chte_pkg::node_we_t             node_we;
  logic [PW-1:0]                  node_waddr;
  logic                           node_wlvld;
  logic [PW-1:0]                  node_wlptr;
  logic [PW-1:0]                  node_raddr;
  logic [chte_pkg::KEY_W-1:0]     nd_key;
  logic [VALUE_BITS-1:0]          nd_val;
  logic                           nd_lvld;
  logic [PW-1:0]                  nd_lptr;

  logic                           hit;
  logic                           resolve;
  logic                           cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(bcount_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= chte_pkg::CFG_W'(10);
    end else if (cfg_wr && (paddr[2] == 1'b0)) begin
      bcount_r <= pwdata[chte_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    if (bcount_r == '0) begin
      divisor = chte_pkg::CFG_W'(1);
    end else if (32'(bcount_r) > 32'(MAX_BUCKETS)) begin
      divisor = chte_pkg::CFG_W'(MAX_BUCKETS);
    end else begin
      divisor = bcount_r;
    end
  end

  assign hash_in = chte_pkg::HASH_W'(in_key) * chte_pkg::HASH_W'(chte_pkg::HASH_MULT);

  chte_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (hash_in),
    .divisor  (divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign bkt_waddr = (state_r == S_CLEAR) ? clr_r : BW'(mod_rem);

  chte_bucket_mem #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_NODES  (POOL_NODES)
  ) u_bucket (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wvld  (bkt_wvld),
    .wptr  (bkt_wptr),
    .raddr (BW'(mod_rem)),
    .rvld  (hd_vld),
    .rptr  (hd_ptr)
  );

  assign node_raddr = (state_r == S_HEAD) ? hd_ptr : nd_lptr;

  chte_node_mem #(
    .POOL_NODES (POOL_NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_node (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wkey  (key_r),
    .wval  (val_r),
    .wlvld (node_wlvld),
    .wlptr (node_wlptr),
    .raddr (node_raddr),
    .rkey  (nd_key),
    .rval  (nd_val),
    .rlvld (nd_lvld),
    .rlptr (nd_lptr)
  );

  assign hit     = (state_r == S_NODE) && (nd_key == key_r);
  assign resolve = ((state_r == S_HEAD) && !hd_vld) ||
                   ((state_r == S_NODE) && (hit || !nd_lvld));

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    used_nxt       = used_r;
    chain_nxt      = chain_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    res_col_nxt    = res_col_r;
    mod_start      = 1'b0;
    bkt_we         = 1'b0;
    bkt_wvld       = 1'b0;
    bkt_wptr       = '0;
    node_we        = '0;
    node_waddr     = cur_r;
    node_wlvld     = 1'b0;
    node_wlptr     = '0;
    out_load       = 1'b0;
    case (state_r)
      S_CLEAR: begin
        bkt_we = 1'b1;
        if (clr_r == BW'(MAX_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          key_nxt        = in_key;
          val_nxt        = VALUE_BITS'(in_data_word);
          chain_nxt      = 1'b0;
          res_status_nxt = chte_pkg::ST_OK;
          res_val_nxt    = '0;
          res_col_nxt    = 1'b0;
          if (in_opcode == chte_pkg::OP_NONE) begin
            state_nxt = S_DONE;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (hd_vld) begin
          cur_nxt   = hd_ptr;
          chain_nxt = 1'b1;
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        if (!resolve) begin
          cur_nxt = nd_lptr;
        end
      end
      S_WNEW: begin
        node_we     = '{key: 1'b1, value: 1'b1, link: 1'b1};
        node_waddr  = used_r[PW-1:0];
        res_col_nxt = chain_r;
        if (chain_r) begin
          state_nxt = S_WTAIL;
        end else begin
          bkt_we    = 1'b1;
          bkt_wvld  = 1'b1;
          bkt_wptr  = used_r[PW-1:0];
          used_nxt  = used_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_WTAIL: begin
        node_we.link = 1'b1;
        node_wlvld   = 1'b1;
        node_wlptr   = used_r[PW-1:0];
        used_nxt     = used_r + 1'b1;
        state_nxt    = S_DONE;
      end
      S_WALT: begin
        node_we.value = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (resolve) begin
      state_nxt = S_DONE;
      case (op_r)
        chte_pkg::OP_INSERT: begin
          if (hit) begin
            res_status_nxt = chte_pkg::ST_DUP;
          end else if (used_r == UW'(POOL_NODES)) begin
            res_status_nxt = chte_pkg::ST_FULL;
          end else begin
            state_nxt = S_WNEW;
          end
        end
        chte_pkg::OP_RETRIEVE: begin
          if (hit) begin
            res_val_nxt = chte_pkg::DATA_W'(nd_val);
          end else begin
            res_status_nxt = chte_pkg::ST_MISS;
          end
        end
        chte_pkg::OP_ALTER: begin
          if (hit) begin
            state_nxt = S_WALT;
          end else begin
            res_status_nxt = chte_pkg::ST_MISS;
          end
        end
        default: begin
          state_nxt = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    chain_r      <= chain_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    res_col_r    <= res_col_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_val_r    <= res_val_r;
      out_col_r    <= res_col_r;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_val_r;
  assign out_collided   = out_col_r;

  `ASSERT_IMPL(a_new_node_in_pool, state_r == S_WNEW, used_r < UW'(POOL_NODES),
               "new node written beyond the pool")
  `ASSERT_IMPL(a_tail_needs_chain, state_r == S_WTAIL, chain_r,
               "tail link written for an empty bucket")
  `ASSERT_IMPL(a_rem_done_in_hash, mod_done, state_r == S_HASH,
               "remainder finished outside the hash step")
  `ASSERT_NEXT(a_beat_starts_hash,
               in_valid && !in_stall && (in_opcode != chte_pkg::OP_NONE),
               state_r == S_HASH, "request beat did not start hashing")

endmodule
